// ----- hdl/zrb_pkg.sv -----
// Package for the zoom region bounds and grid unit.
// Widths, config register indexes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package zrb_pkg;

  localparam int POS_BITS  = 32;
  localparam int BUF_BITS  = 16;
  localparam int KIND_BITS = 3;
  localparam int DIV_BITS  = 40;
  localparam int CNT_BITS  = 6;
  localparam int CFG_IDX_BITS = 3;
  localparam logic [15:0] MAX_CELLS = 16'hFFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BOX_X  = 3'd0,
    CFG_BOX_Y  = 3'd1,
    CFG_BOX_Z  = 3'd2,
    CFG_BUF    = 3'd3,
    CFG_KIND   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REGION,
    S_QSTART,
    S_QWAIT,
    S_CELLS,
    S_SWAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic upd;        // fold accepted item into the box
    logic clr;        // restart the box
    logic ld_region;
    logic div_start;
    logic div_sel;    // 0: cell count, 1: top cell size
    logic ld_cells;
    logic ld_small;
    logic ld_out;
  } zrb_cmd_t;

  typedef struct packed {
    logic seen;
    logic div_done;
    logic cells_pos;
  } zrb_stat_t;

endpackage

// ----- hdl/zrb_if.sv -----
// Valid/ready channel interfaces for particle items and results.
// Depends on zrb_pkg.
`timescale 1ns / 1ps
interface zrb_in_if import zrb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [POS_BITS-1:0]  pos_x;
  logic [POS_BITS-1:0]  pos_y;
  logic [POS_BITS-1:0]  pos_z;
  logic [KIND_BITS-1:0] particle_kind;
  logic                 is_last;
  modport source (output valid, pos_x, pos_y, pos_z, particle_kind, is_last, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, particle_kind, is_last, output ready);
endinterface

interface zrb_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] shift_x;
  logic signed [32:0] shift_y;
  logic signed [32:0] shift_z;
  logic signed [16:0] background_cells;
  logic [31:0]        top_cell_size;
  logic               grid_too_small;
  logic               region_empty;
  modport source (output valid, shift_x, shift_y, shift_z, background_cells, top_cell_size,
                  grid_too_small, region_empty, input ready);
  modport sink   (input valid, shift_x, shift_y, shift_z, background_cells, top_cell_size,
                  grid_too_small, region_empty, output ready);
endinterface

// ----- hdl/zrb_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on zrb_pkg.
`timescale 1ns / 1ps
module zrb_div import zrb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] quotient
);
  logic [DIV_BITS:0]   rem_r, rem_nxt, rem_sh, dvs;
  logic [DIV_BITS-1:0] quo_r, quo_nxt, dvs_r;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt, ge;

  always_comb begin
    rem_sh   = {rem_r[DIV_BITS-1:0], quo_r[DIV_BITS-1]};
    dvs      = {1'b0, dvs_r};
    ge       = rem_sh >= dvs;
    rem_nxt  = ge ? rem_sh - dvs : rem_sh;
    quo_nxt  = {quo_r[DIV_BITS-2:0], ge};
    cnt_nxt  = cnt_r + 1'b1;
    busy_nxt = busy_r && (cnt_r != CNT_BITS'(DIV_BITS-1));
    done_nxt = busy_r && (cnt_r == CNT_BITS'(DIV_BITS-1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// ----- hdl/zrb_datapath.sv -----
// Datapath: config registers, running min/max box, region side, shared divider, result regs.
// Depends on zrb_pkg and zrb_div.
`timescale 1ns / 1ps
module zrb_datapath import zrb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [POS_BITS-1:0]     cfg_data,
  input  logic [POS_BITS-1:0]     pos_x,
  input  logic [POS_BITS-1:0]     pos_y,
  input  logic [POS_BITS-1:0]     pos_z,
  input  logic [KIND_BITS-1:0]    kind,
  input  zrb_cmd_t                cmd,
  output zrb_stat_t               stat,
  output logic signed [32:0]      shift_x,
  output logic signed [32:0]      shift_y,
  output logic signed [32:0]      shift_z,
  output logic signed [16:0]      bg_cells,
  output logic [31:0]             cell_size,
  output logic                    too_small,
  output logic                    empty
);
  logic [POS_BITS-1:0]  box_x_r, box_y_r, box_z_r;
  logic [BUF_BITS-1:0]  buf_r;
  logic [KIND_BITS-1:0] kind_r;
  logic [POS_BITS-1:0]  lo_x_r, lo_y_r, lo_z_r, hi_x_r, hi_y_r, hi_z_r;
  logic                 seen_r;
  logic [DIV_BITS-1:0]  region_r;
  logic signed [16:0]   cells_r, cells_nxt;
  logic [48:0]          small_prod_r;
  logic                 match;
  logic [POS_BITS-1:0]  ext_x, ext_y, ext_z, side, dmax, dmin;
  logic [47:0]          region_prod;
  logic [DIV_BITS-1:0]  div_a, div_b, quo;
  logic                 div_done;
  logic [15:0]          q_sat;
  logic [38:0]          num_size;
  logic [22:0]          den_size;
  logic [33:0]          dmax3, dx, dy, dz;
  logic                 small_flag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= POS_BITS'(65536);
      box_y_r <= POS_BITS'(65536);
      box_z_r <= POS_BITS'(65536);
      buf_r   <= BUF_BITS'(256);
      kind_r  <= KIND_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BOX_X: box_x_r <= cfg_data;
        CFG_BOX_Y: box_y_r <= cfg_data;
        CFG_BOX_Z: box_z_r <= cfg_data;
        CFG_BUF:   buf_r   <= cfg_data[BUF_BITS-1:0];
        CFG_KIND:  kind_r  <= cfg_data[KIND_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign match = kind == kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      lo_x_r <= '1; lo_y_r <= '1; lo_z_r <= '1;
      hi_x_r <= '0; hi_y_r <= '0; hi_z_r <= '0;
      seen_r <= 1'b0;
    end else if (cmd.upd && match) begin
      if (pos_x < lo_x_r) lo_x_r <= pos_x;
      if (pos_x > hi_x_r) hi_x_r <= pos_x;
      if (pos_y < lo_y_r) lo_y_r <= pos_y;
      if (pos_y > hi_y_r) hi_y_r <= pos_y;
      if (pos_z < lo_z_r) lo_z_r <= pos_z;
      if (pos_z > hi_z_r) hi_z_r <= pos_z;
      seen_r <= 1'b1;
    end
  end

  always_comb begin
    ext_x = hi_x_r - lo_x_r;
    ext_y = hi_y_r - lo_y_r;
    ext_z = hi_z_r - lo_z_r;
    side  = ext_x;
    if (ext_y > side) side = ext_y;
    if (ext_z > side) side = ext_z;
    region_prod = side * buf_r;
    dmax = box_x_r;
    if (box_y_r > dmax) dmax = box_y_r;
    if (box_z_r > dmax) dmax = box_z_r;
    dmin = box_x_r;
    if (box_y_r < dmin) dmin = box_y_r;
    if (box_z_r < dmin) dmin = box_z_r;
    num_size = dmax * 7'd99;
    den_size = cells_r[15:0] * 7'd100;
    div_a = cmd.div_sel ? DIV_BITS'(num_size) : DIV_BITS'(box_x_r);
    div_b = cmd.div_sel ? DIV_BITS'(den_size) : region_r;
    // count saturates; zero region side counts as saturated
    if (region_r == '0 || quo > DIV_BITS'(MAX_CELLS)) q_sat = MAX_CELLS;
    else                                               q_sat = quo[15:0];
    cells_nxt = $signed({1'b0, q_sat}) - $signed({16'b0, ~q_sat[0]});
    dmax3 = {2'b0, dmax} + {1'b0, dmax, 1'b0};
    small_flag = cells_r[16] || (cells_r == '0) || (small_prod_r <= {15'b0, dmax3});
    dx = {2'b0, box_x_r} - {2'b0, lo_x_r} - {2'b0, hi_x_r};
    dy = {2'b0, box_x_r} - {2'b0, lo_y_r} - {2'b0, hi_y_r};
    dz = {2'b0, box_x_r} - {2'b0, lo_z_r} - {2'b0, hi_z_r};
  end

  zrb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_region) region_r <= region_prod[47:8];
    if (cmd.ld_cells)  cells_r  <= cells_nxt;
    if (cmd.ld_small)  small_prod_r <= ({16'b0, cells_r[15:0]} + 32'd1) * {17'b0, dmin};
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      if (!seen_r) begin
        shift_x <= '0; shift_y <= '0; shift_z <= '0;
        bg_cells <= '0; cell_size <= '0; too_small <= 1'b0; empty <= 1'b1;
      end else begin
        shift_x   <= $signed(dx[33:1]);
        shift_y   <= $signed(dy[33:1]);
        shift_z   <= $signed(dz[33:1]);
        bg_cells  <= cells_r;
        cell_size <= (cells_r[16] || cells_r == '0) ? 32'd0 : quo[31:0];
        too_small <= small_flag;
        empty     <= 1'b0;
      end
    end
  end

  assign stat.seen      = seen_r;
  assign stat.div_done  = div_done;
  assign stat.cells_pos = !cells_r[16] && (cells_r != '0);
endmodule

// ----- hdl/zrb_ctrl.sv -----
// Controller: sequences box update, the two divisions and the result load.
// Depends on zrb_pkg.
`timescale 1ns / 1ps
module zrb_ctrl import zrb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_is_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output zrb_cmd_t  cmd,
  input  zrb_stat_t stat
);
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.upd = 1'b1;
          if (in_is_last) state_nxt = S_REGION;
        end
      end
      S_REGION: begin
        cmd.ld_region = 1'b1;
        state_nxt = stat.seen ? S_QSTART : S_OUT;
      end
      S_QSTART: begin
        cmd.div_start = 1'b1;
        state_nxt = S_QWAIT;
      end
      S_QWAIT: begin
        if (stat.div_done) begin
          cmd.ld_cells = 1'b1;
          state_nxt = S_CELLS;
        end
      end
      S_CELLS: begin
        cmd.ld_small = 1'b1;
        if (stat.cells_pos) begin
          cmd.div_sel   = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt = S_SWAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SWAIT: begin
        if (stat.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          cmd.clr       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
endmodule

// ----- hdl/zoom_region_bounds_and_grid_unit.sv -----
// Top level of the zoom region bounds and grid unit.
// Depends on zrb_pkg, zrb_if, zrb_ctrl, zrb_datapath.
//
// Use: particles arrive on in_ch (valid/ready). Each transfer whose kind matches
// the selected_kind register widens a running min/max box; in_ready stays high
// for back-to-back transfers of non-last particles, and a transfer with is_last
// set closes the set: in_ready drops and the unit works out region side (one
// 32x16 multiply), cell count (restoring divide), too-small product and top cell
// size (second divide on the same divider, only when the count is positive).
// One result per set is held in an output register. If the receiver stalls,
// new particles are still taken; only the next set's result waits in the
// load step until the held result is transferred. The box restarts when the
// result is loaded.
// Config: cfg_we/cfg_idx/cfg_data write one register per cycle; write only
// while idle.
// Reset (rst_n low, synchronous) restores register defaults, empties the box
// and drops out valid.
`timescale 1ns / 1ps
module zoom_region_bounds_and_grid_unit import zrb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [POS_BITS-1:0]     cfg_data,
  zrb_in_if.sink                  in_ch,
  zrb_out_if.source               out_ch
);
  zrb_cmd_t  cmd;
  zrb_stat_t stat;

  zrb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_is_last(in_ch.is_last), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  zrb_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .pos_x(in_ch.pos_x), .pos_y(in_ch.pos_y), .pos_z(in_ch.pos_z),
    .kind(in_ch.particle_kind),
    .cmd(cmd), .stat(stat),
    .shift_x(out_ch.shift_x), .shift_y(out_ch.shift_y), .shift_z(out_ch.shift_z),
    .bg_cells(out_ch.background_cells), .cell_size(out_ch.top_cell_size),
    .too_small(out_ch.grid_too_small), .empty(out_ch.region_empty)
  );
endmodule

// ----- hdl/zrb_checker.sv -----
// Port-level checks for the zoom region bounds and grid unit, bound to the top.
// Depends on zoom_region_bounds_and_grid_unit.
`timescale 1ns / 1ps
module zrb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_is_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] bg_cells,
  input logic [31:0]        cell_size,
  input logic               too_small,
  input logic               empty
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bg_cells) && $stable(cell_size))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> !in_ready)
    else $error("input taken during computation");

  a_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !empty |-> bg_cells[0])
    else $error("cell count not odd");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty |-> bg_cells == '0 && cell_size == '0 && !too_small)
    else $error("empty result carries data");

  a_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !empty && bg_cells[16] |-> cell_size == '0 && too_small)
    else $error("negative count result wrong");
endmodule

bind zoom_region_bounds_and_grid_unit zrb_checker u_zrb_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_is_last(in_ch.is_last),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .bg_cells(out_ch.background_cells), .cell_size(out_ch.top_cell_size),
  .too_small(out_ch.grid_too_small), .empty(out_ch.region_empty)
);

// ----- verif/zrb_result_checker.sv -----
// Checker for the zoom region bounds and grid unit: mirrors config writes, folds
// particle transfers into its own box and compares each result transfer.
// Depends on zrb_pkg and zrb_if.
`timescale 1ns / 1ps
module zrb_result_checker import zrb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [POS_BITS-1:0]     cfg_data,
  zrb_in_if                       in_ch,
  zrb_out_if                      out_ch,
  output int                      fail_count,
  output int                      results_owed
);

  typedef struct {
    logic [32:0] shift_x;
    logic [32:0] shift_y;
    logic [32:0] shift_z;
    logic [16:0] cells;
    logic [31:0] cell_size;
    logic        too_small;
    logic        empty;
  } grid_result_t;

  grid_result_t awaited_results[$];

  logic [31:0] box_x, box_y, box_z;
  logic [15:0] buf_factor;
  logic [2:0]  tracked_kind;
  logic [31:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic        any_seen;

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    $display("MISMATCH %s: expected %h, got %h", field, want, got);
    fail_count++;
  endtask

  function automatic logic [32:0] centring(logic [31:0] lo, logic [31:0] hi);
    logic signed [63:0] d;
    d = $signed({32'd0, box_x}) - $signed({32'd0, lo}) - $signed({32'd0, hi});
    return d[33:1]; // arithmetic floor of d/2
  endfunction

  task automatic clear_box();
    lo_x = '1; lo_y = '1; lo_z = '1;
    hi_x = '0; hi_y = '0; hi_z = '0;
    any_seen = 1'b0;
  endtask

  // Fold one particle; on the closing one, queue the grid result.
  task automatic fold_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [2:0] kind, logic last);
    grid_result_t r;
    logic [63:0] side, region, dmax, dmin, q, size;
    logic signed [63:0] cnt;
    if (kind == tracked_kind) begin
      if (px < lo_x) lo_x = px;
      if (px > hi_x) hi_x = px;
      if (py < lo_y) lo_y = py;
      if (py > hi_y) hi_y = py;
      if (pz < lo_z) lo_z = pz;
      if (pz > hi_z) hi_z = pz;
      any_seen = 1'b1;
    end
    if (!last) return;
    r = '{default: '0};
    if (!any_seen) begin
      r.empty = 1'b1;
    end else begin
      side = 64'(hi_x - lo_x);
      if (64'(hi_y - lo_y) > side) side = 64'(hi_y - lo_y);
      if (64'(hi_z - lo_z) > side) side = 64'(hi_z - lo_z);
      region = (side * buf_factor) >> 8;
      dmax = 64'(box_x); dmin = 64'(box_x);
      if (box_y > dmax) dmax = 64'(box_y);
      if (box_z > dmax) dmax = 64'(box_z);
      if (box_y < dmin) dmin = 64'(box_y);
      if (box_z < dmin) dmin = 64'(box_z);
      if (region == 0) begin
        cnt = 64'(MAX_CELLS);
      end else begin
        q = box_x / region;
        cnt = (q > MAX_CELLS) ? 64'(MAX_CELLS) : q;
      end
      if (!cnt[0]) cnt = cnt - 1;
      if (cnt <= 0) begin
        r.cell_size = '0;
        r.too_small = 1'b1;
      end else begin
        size = (dmax * 99) / (100 * cnt);
        r.cell_size = size[31:0];
        r.too_small = ((cnt + 1) * dmin <= 3 * dmax);
      end
      r.shift_x = centring(lo_x, hi_x);
      r.shift_y = centring(lo_y, hi_y);
      r.shift_z = centring(lo_z, hi_z);
      r.cells   = cnt[16:0];
    end
    awaited_results.push_back(r);
    clear_box();
  endtask

  always @(posedge clk) begin
    grid_result_t w;
    if (!rst_n) begin
      box_x = 32'd65536; box_y = 32'd65536; box_z = 32'd65536;
      buf_factor = 16'd256;
      tracked_kind = 3'd1;
      clear_box();
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_BOX_X: box_x = cfg_data;
          CFG_BOX_Y: box_y = cfg_data;
          CFG_BOX_Z: box_z = cfg_data;
          CFG_BUF:   buf_factor = cfg_data[15:0];
          CFG_KIND:  tracked_kind = cfg_data[2:0];
          default: ;
        endcase
      end
      // result first: it can never come from a particle taken on this same edge
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report("unexpected result", '0, '1);
        end else begin
          w = awaited_results.pop_front();
          if (out_ch.shift_x !== w.shift_x)
            report("shift_x", 64'(w.shift_x), 64'(out_ch.shift_x));
          if (out_ch.shift_y !== w.shift_y)
            report("shift_y", 64'(w.shift_y), 64'(out_ch.shift_y));
          if (out_ch.shift_z !== w.shift_z)
            report("shift_z", 64'(w.shift_z), 64'(out_ch.shift_z));
          if (out_ch.background_cells !== w.cells)
            report("background_cells", 64'(w.cells), 64'(out_ch.background_cells));
          if (out_ch.top_cell_size !== w.cell_size)
            report("top_cell_size", 64'(w.cell_size), 64'(out_ch.top_cell_size));
          if (out_ch.grid_too_small !== w.too_small)
            report("grid_too_small", 64'(w.too_small), 64'(out_ch.grid_too_small));
          if (out_ch.region_empty !== w.empty)
            report("region_empty", 64'(w.empty), 64'(out_ch.region_empty));
        end
      end
      if (in_ch.valid && in_ch.ready)
        fold_particle(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.particle_kind,
                      in_ch.is_last);
    end
    results_owed = awaited_results.size();
  end

endmodule

// ----- verif/zoom_region_bounds_and_grid_unit_test.sv -----
// Top of the zoom region bounds and grid unit testbench: clock, reset, config
// phases, particle stimulus and the verdict. Checking lives in zrb_result_checker.
// Depends on zrb_pkg, zrb_if, zrb_result_checker and the unit itself.
`timescale 1ns / 1ps
module zoom_region_bounds_and_grid_unit_test;
  import zrb_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES  = 120;    // settle time after the last result transfer
  localparam int RAND_PER_PHASE = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [POS_BITS-1:0] cfg_data = '0;
  int fail_count, results_owed;
  int cycles = 0;
  int burst_left = 0;
  logic [2:0] kind_now = 3'd1;   // tracked kind of the current phase

  zrb_in_if  in_ch();
  zrb_out_if out_ch();

  zoom_region_bounds_and_grid_unit u_dut (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .in_ch(in_ch), .out_ch(out_ch)
  );

  zrb_result_checker u_check (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .in_ch(in_ch), .out_ch(out_ch),
    .fail_count, .results_owed
  );

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.particle_kind = '0; in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("zoom_region_bounds_and_grid_unit verification failed");
      $finish;
    end
  end

  // Receiver stall pattern: the mode is redrawn at random among always-ready,
  // coin flip, and long stalls with rare ready.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                            logic [15:0] bf, logic [2:0] kd);
    write_reg(CFG_BOX_X, bx);
    write_reg(CFG_BOX_Y, by);
    write_reg(CFG_BOX_Z, bz);
    write_reg(CFG_BUF, {16'd0, bf});
    write_reg(CFG_KIND, {29'd0, kd});
    cfg_we <= 1'b0;
    kind_now = kd;
  endtask

  // One particle transfer; sender may idle between bursts of random length.
  task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [2:0] kd, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.particle_kind <= kd;
    in_ch.is_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Wait until every result has been transferred, then let the unit settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random sets: mostly tracked-kind particles clustered around a base (random
  // spread, up to half the range) or spread over the full range; some sets hold no
  // tracked particle at all.
  task automatic random_sets(int n_items);
    int sent, len, spread, style;
    logic [31:0] bx, by, bz;
    logic [2:0] kd;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      style = $urandom_range(0, 9);
      spread = 1 << $urandom_range(0, 31);
      bx = $urandom; by = $urandom; bz = $urandom;
      for (int i = 0; i < len; i++) begin
        if (style == 0)
          kd = 3'((kind_now + $urandom_range(1, 7)) % 8);    // never the tracked kind
        else if ($urandom_range(0, 4) == 0)
          kd = 3'($urandom_range(0, 7));
        else
          kd = kind_now;
        if (style < 4)
          send_particle($urandom, $urandom, $urandom, kd, i == len - 1);
        else
          send_particle(bx + $urandom_range(0, spread - 1),
                        by + $urandom_range(0, spread - 1),
                        bz + $urandom_range(0, spread - 1), kd, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset configuration (box 1.0, buffer 1.0, kind 1).
    send_particle(32'd0, 32'd0, 32'd0, 3'd0, 1'b1);                   // empty set
    send_particle(32'h8000, 32'h8000, 32'h8000, 3'd1, 1'b1);          // zero region side
    send_particle(32'd0, 32'd0, 32'd0, 3'd1, 1'b0);
    send_particle('1, '1, '1, 3'd1, 1'b1);                            // count goes to -1
    for (int k = 0; k < 8; k++)
      send_particle(32'h1000 * k, 32'h800 * k, 32'h400 * k, 3'(k), k == 7);
    send_particle(32'h100, 32'h100, 32'h100, 3'd2, 1'b0);
    send_particle(32'h4000, 32'h100, 32'h100, 3'd1, 1'b1);            // last is tracked
    send_particle(32'h7000, 32'h9000, 32'h8000, 3'd1, 1'b0);
    send_particle(32'h7100, 32'h8f00, 32'h8001, 3'd1, 1'b1);
    random_sets(RAND_PER_PHASE);
    drain();

    // Upper extremes.
    set_config('1, '1, '1, 16'hFFFF, 3'd7);
    send_particle('1, 32'd0, 32'h5555_5555, 3'd7, 1'b0);
    send_particle(32'd0, '1, 32'hAAAA_AAAA, 3'd7, 1'b1);
    send_particle(32'd12, 32'd12, 32'd12, 3'd7, 1'b1);
    random_sets(RAND_PER_PHASE);
    drain();

    // Lower extremes.
    set_config(32'd1, 32'd1, 32'd1, 16'd0, 3'd0);
    send_particle(32'd0, '1, 32'd3, 3'd0, 1'b1);
    send_particle(32'd0, 32'd0, 32'd0, 3'd5, 1'b1);
    random_sets(RAND_PER_PHASE);
    drain();

    // Random settings, uneven box lengths.
    for (int p = 0; p < 3; p++) begin
      set_config($urandom_range(1, 32'hFFFF_FFFF) | 32'd1, $urandom | 32'h1,
                 32'h1 << $urandom_range(0, 31), 16'($urandom_range(0, 16'hFFFF)),
                 3'($urandom_range(0, 7)));
      random_sets(RAND_PER_PHASE / 2);
      drain();
    end

    if (fail_count == 0)
      $display("zoom_region_bounds_and_grid_unit verification clean");
    else
      $display("zoom_region_bounds_and_grid_unit verification failed");
    $finish;
  end

endmodule
